// ===== hdl/tgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_pkg: shared types and constants
// Field widths, operation and gesture codes, register indexes, the arctangent
// table and the command and status records between controller and datapath.
// ----------------------------------------------------------------------------
package tgd_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int STEP_W = 5;
  localparam int SMOOTH_W = 24;
  localparam int ANGLE_W = 12;
  localparam int ATAN_W = 23;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_ARM = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [2:0] G_NONE = 3'd0;
  localparam logic [2:0] G_LEFT = 3'd1;
  localparam logic [2:0] G_RIGHT = 3'd2;
  localparam logic [2:0] G_FRONT = 3'd3;
  localparam logic [2:0] G_BACK = 3'd4;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_RETURN = 2'd1;
  localparam logic [1:0] REG_HOLD = 2'd2;
  localparam logic [1:0] REG_DELAY = 2'd3;

  // atan(2^-i) in units of 2^-16 degree.
  localparam logic [ATAN_W-1:0] ATAN_TAB [24] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
    23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
    23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
  };

  typedef struct packed {
    logic capture;
    logic clr_all;
    logic set_arm;
    logic load_raw;
    logic load_smooth;
    logic sq0;
    logic sq1;
    logic sq2;
    logic sqrt_step;
    logic cor_init;
    logic cor_step;
    logic fin;
    logic roll;
    logic store_ref;
    logic detect;
    logic arm_ok;
    logic out_load;
    logic [STEP_W-1:0] step;
  } tgd_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic ok;
    logic armed;
    logic ref_taken;
  } tgd_status_t;

endpackage
`default_nettype wire

// ===== hdl/tgd_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_sample_if: input item channel
// Carries one command or accelerometer sample with valid and ready.
// ----------------------------------------------------------------------------
interface tgd_sample_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic sample_ok;
  logic signed [15:0] accel_x_mg;
  logic signed [15:0] accel_y_mg;
  logic signed [15:0] accel_z_mg;
  logic [31:0] time_ms;
  modport source (output valid, opcode, sample_ok, accel_x_mg, accel_y_mg, accel_z_mg,
                  time_ms, input ready);
  modport sink (input valid, opcode, sample_ok, accel_x_mg, accel_y_mg, accel_z_mg,
                time_ms, output ready);
endinterface
`default_nettype wire

// ===== hdl/tgd_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_result_if: result item channel
// Carries the reported gesture and the arm acknowledge with valid and ready.
// ----------------------------------------------------------------------------
interface tgd_result_if;
  logic valid;
  logic ready;
  logic [2:0] gesture;
  logic arm_ok;
  modport source (output valid, gesture, arm_ok, input ready);
  modport sink (input valid, gesture, arm_ok, output ready);
endinterface
`default_nettype wire

// ===== hdl/tgd_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_cfg_if: configuration write channel
// Carries a register index and write data with valid and ready.
// ----------------------------------------------------------------------------
interface tgd_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tilt_gesture_detector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_gesture_detector_core: tilt gesture detector top level
// Smooths accelerometer samples, derives pitch and roll and reports gestures.
// ----------------------------------------------------------------------------
// Each item on the sample channel is a command: a sample update, an arm that
// captures the baseline, or a full reset. Every item gives exactly one item on
// the result channel, carrying the gesture code and the arm acknowledge.
// Configuration writes arrive on the cfg channel, which is always ready, and
// must only be issued while the block is idle.
// An item that needs no angles goes from dispatch straight to the output load.
// An item that computes angles runs the squarer states SQ0, SQ1 and SQ2, a 24-step
// root, a CORDIC load, CORDIC_STEPS iterations and a rounding step, once for pitch
// and once for roll, plus dispatch, detection and output load. One item is
// handled at a time, and the next is accepted at the earliest in the cycle in
// which the result appears.
// If the receiver stalls, the next item is still accepted and processed, but
// its result waits until the previous one has been taken.
// Reset clears the detector state and restores the register defaults:
// threshold 25.0 degrees, return band 20.0 degrees, hold 5, delay 100 ms.
// ----------------------------------------------------------------------------
module tilt_gesture_detector_core
  import tgd_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input wire clk,
  input wire rst,
  tgd_sample_if.sink sample,
  tgd_result_if.source result,
  tgd_cfg_if.sink cfg
);

  tgd_cmd_t cmd;
  tgd_status_t status;

  // The register file never stalls.
  assign cfg.ready = 1'b1;

  // The sequencer owns both handshakes; the datapath only follows commands.
  tgd_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(sample.valid),
    .in_ready(sample.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .status(status),
    .cmd(cmd)
  );

  tgd_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .in_opcode(sample.opcode),
    .in_ok(sample.sample_ok),
    .in_x(sample.accel_x_mg),
    .in_y(sample.accel_y_mg),
    .in_z(sample.accel_z_mg),
    .in_time(sample.time_ms),
    .cfg_we(cfg.valid),
    .cfg_index(cfg.index),
    .cfg_data(cfg.data),
    .res_gesture(result.gesture),
    .res_arm_ok(result.arm_ok)
  );

endmodule
`default_nettype wire

// ===== hdl/tgd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_ctrl: sequencing state machine
// Walks each item through filter, square sums, root, CORDIC and detection.
// ----------------------------------------------------------------------------
module tgd_ctrl
  import tgd_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire          out_ready,
  input  wire tgd_status_t status,
  output tgd_cmd_t     cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SQ0 = 4'd2;
  localparam logic [3:0] S_SQ1 = 4'd3;
  localparam logic [3:0] S_SQ2 = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_CORI = 4'd6;
  localparam logic [3:0] S_COR = 4'd7;
  localparam logic [3:0] S_FIN = 4'd8;
  localparam logic [3:0] S_POST = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;

  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SMOOTH_W - 1);
  localparam logic [STEP_W-1:0] COR_LAST = STEP_W'(CORDIC_STEPS - 1);

  logic [3:0] state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic roll, roll_next;
  logic base, base_next;
  logic armok, armok_next;
  logic detect_run, detect_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    roll_next = roll;
    base_next = base;
    armok_next = armok;
    detect_next = detect_run;
    cmd = '0;
    cmd.step = cnt;
    cmd.roll = roll;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          armok_next = 1'b0;
          base_next = 1'b0;
          detect_next = 1'b0;
          roll_next = 1'b0;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_OUT;
        case (status.op)
          OP_RESET: cmd.clr_all = 1'b1;
          OP_ARM: begin
            cmd.clr_all = 1'b1;
            cmd.set_arm = 1'b1;
            if (status.ok) begin
              cmd.load_raw = 1'b1;
              base_next = 1'b1;
              armok_next = 1'b1;
              state_next = S_SQ0;
            end
          end
          OP_UPDATE: begin
            if (status.armed && status.ok) begin
              if (!status.ref_taken) begin
                cmd.load_raw = 1'b1;
                base_next = 1'b1;
              end else begin
                cmd.load_smooth = 1'b1;
                detect_next = 1'b1;
              end
              state_next = S_SQ0;
            end
          end
          default: state_next = S_OUT;
        endcase
      end
      S_SQ0: begin
        cmd.sq0 = 1'b1;
        state_next = S_SQ1;
      end
      S_SQ1: begin
        cmd.sq1 = 1'b1;
        state_next = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq2 = 1'b1;
        cnt_next = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == SQRT_LAST) begin
          state_next = S_CORI;
        end
      end
      S_CORI: begin
        cmd.cor_init = 1'b1;
        cnt_next = '0;
        state_next = S_COR;
      end
      S_COR: begin
        cmd.cor_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == COR_LAST) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (!roll) begin
          roll_next = 1'b1;
          state_next = S_SQ0;
        end else begin
          state_next = S_POST;
        end
      end
      S_POST: begin
        cmd.store_ref = base;
        cmd.detect = detect_run;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid) begin
          cmd.out_load = 1'b1;
          cmd.arm_ok = armok;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      roll <= 1'b0;
      base <= 1'b0;
      armok <= 1'b0;
      detect_run <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      roll <= roll_next;
      base <= base_next;
      armok <= armok_next;
      detect_run <= detect_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tgd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_datapath: filter, angle and detection datapath
// Holds the detector state, the configuration registers, the shared squarer,
// the digit-by-digit square root, the CORDIC and the gesture logic.
// ----------------------------------------------------------------------------
module tgd_datapath
  import tgd_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire tgd_cmd_t cmd,
  output tgd_status_t  status,
  input  wire [1:0]    in_opcode,
  input  wire          in_ok,
  input  wire [15:0]   in_x,
  input  wire [15:0]   in_y,
  input  wire [15:0]   in_z,
  input  wire [31:0]   in_time,
  input  wire          cfg_we,
  input  wire [1:0]    cfg_index,
  input  wire [15:0]   cfg_data,
  output logic [2:0]   res_gesture,
  output logic         res_arm_ok
);

  localparam int XW = 28;
  localparam int ZW = 32;
  localparam int SQ_W = 2 * SMOOTH_W;

  // Configuration.
  logic [9:0] thresh, band;
  logic [3:0] hold;
  logic [15:0] delay;

  // Latched item.
  logic [1:0] op;
  logic ok;
  logic signed [15:0] ax, ay, az;
  logic [31:0] now;

  // Detector state.
  logic signed [SMOOTH_W-1:0] sx, sy, sz;
  logic primed, armed, ref_taken;
  logic signed [ANGLE_W-1:0] ref_p, ref_r, pitch, roll;
  logic [2:0] steady_class, locked_class, waiting_class, gest;
  logic [3:0] steady_count;
  logic [31:0] waiting_since;

  // Arithmetic.
  logic signed [SQ_W-1:0] prod;
  logic [SQ_W-1:0] rad;
  logic [SMOOTH_W+1:0] rem;
  logic [SMOOTH_W-1:0] root;
  logic signed [XW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;

  assign status = '{op: op, ok: ok, armed: armed, ref_taken: ref_taken};

  function automatic logic signed [SMOOTH_W-1:0] iir(input logic signed [SMOOTH_W-1:0] s,
                                                      input logic signed [15:0] a);
    logic signed [35:0] v;
    begin
      v = (36'(s) * 36'sd179 + 36'(a) * 36'sd19712 + 36'sd128) >>> 8;
      if (v > 36'sd8388607) begin
        v = 36'sd8388607;
      end else if (v < -36'sd8388608) begin
        v = -36'sd8388608;
      end
      iir = v[SMOOTH_W-1:0];
    end
  endfunction

  function automatic logic [10:0] mag(input logic signed [12:0] v);
    logic signed [12:0] a;
    begin
      a = (v < 0) ? -v : v;
      mag = a[10:0];
    end
  endfunction

  // Operand selection: pitch uses x over sqrt(y^2+z^2), roll y over sqrt(x^2+z^2).
  logic signed [SMOOTH_W-1:0] sq_a, num;
  assign sq_a = cmd.roll ? sx : sy;
  assign num = cmd.roll ? sy : sx;

  // Square root step: two radicand bits in, one root bit out.
  logic [SMOOTH_W+1:0] rem_sh, trial;
  assign rem_sh = {rem[SMOOTH_W-1:0], rad[SQ_W-1 -: 2]};
  assign trial = {root, 2'b01};

  // CORDIC step.
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  assign xs = cx >>> cmd.step;
  assign ys = cy >>> cmd.step;
  assign at = ZW'(ATAN_TAB[cmd.step]);

  // Rounding to tenths of a degree.
  logic signed [ZW+3:0] z10, zt;
  logic signed [ANGLE_W-1:0] ang;
  always_comb begin
    z10 = ((ZW+4)'(cz) <<< 3) + ((ZW+4)'(cz) <<< 1) + (ZW+4)'(32768);
    zt = z10 >>> 16;
    if (num == '0) begin
      ang = '0;
    end else if (zt > (ZW+4)'(900)) begin
      ang = ANGLE_W'(900);
    end else if (zt < -(ZW+4)'(900)) begin
      ang = -ANGLE_W'(900);
    end else begin
      ang = zt[ANGLE_W-1:0];
    end
  end

  // Classification and detection.
  logic signed [12:0] dp, dr;
  logic [10:0] mp, mr;
  logic [2:0] cur;
  logic release_lock;
  logic [2:0] steady_class_next, locked_class_next, waiting_class_next, gest_next;
  logic [3:0] steady_count_next;
  logic [31:0] waiting_since_next;

  always_comb begin
    dp = 13'(pitch) - 13'(ref_p);
    dr = 13'(roll) - 13'(ref_r);
    mp = mag(dp);
    mr = mag(dr);
    if (mp < 11'(thresh) && mr < 11'(thresh)) begin
      cur = G_NONE;
    end else if (mp >= mr) begin
      cur = (dp > 0) ? G_LEFT : G_RIGHT;
    end else begin
      cur = (dr > 0) ? G_BACK : G_FRONT;
    end
    release_lock = (locked_class != G_NONE) && (mp < 11'(band)) && (mr < 11'(band));

    steady_class_next = steady_class;
    steady_count_next = steady_count;
    locked_class_next = locked_class;
    waiting_class_next = waiting_class;
    waiting_since_next = waiting_since;
    gest_next = G_NONE;
    if (release_lock) begin
      steady_class_next = G_NONE;
      steady_count_next = '0;
      locked_class_next = G_NONE;
      waiting_class_next = G_NONE;
      waiting_since_next = '0;
    end else begin
      if (cur == steady_class) begin
        if (steady_count < hold) begin
          steady_count_next = steady_count + 1'b1;
        end
      end else begin
        steady_class_next = cur;
        steady_count_next = '0;
        waiting_class_next = G_NONE;
        waiting_since_next = '0;
      end
      if (locked_class != G_NONE || cur == G_NONE || steady_count_next < hold) begin
        gest_next = G_NONE;
      end else if (waiting_class_next == G_NONE) begin
        waiting_class_next = cur;
        waiting_since_next = now;
      end else if (waiting_class_next != cur) begin
        waiting_class_next = G_NONE;
        waiting_since_next = now;
      end else if ((now - waiting_since_next) >= {16'd0, delay}) begin
        locked_class_next = cur;
        waiting_class_next = G_NONE;
        gest_next = cur;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= 10'd250;
      band <= 10'd200;
      hold <= 4'd5;
      delay <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thresh <= cfg_data[9:0];
        REG_RETURN: band <= cfg_data[9:0];
        REG_HOLD: hold <= cfg_data[3:0];
        REG_DELAY: delay <= cfg_data;
      endcase
    end
  end

  // Item latch and arithmetic working registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= in_opcode;
      ok <= in_ok;
      ax <= in_x;
      ay <= in_y;
      az <= in_z;
      now <= in_time;
    end
    if (cmd.sq0) begin
      prod <= sq_a * sq_a;
    end
    if (cmd.sq1) begin
      rad <= prod;
      prod <= sz * sz;
    end
    if (cmd.sq2) begin
      rad <= rad + prod;
      rem <= '0;
      root <= '0;
    end
    if (cmd.sqrt_step) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        root <= {root[SMOOTH_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[SMOOTH_W-2:0], 1'b0};
      end
    end
    if (cmd.cor_init) begin
      cx <= XW'(root);
      cy <= XW'(num);
      cz <= '0;
    end
    if (cmd.cor_step) begin
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end
    end
    if (cmd.fin) begin
      if (cmd.roll) begin
        roll <= ang;
      end else begin
        pitch <= ang;
      end
    end
    if (cmd.out_load) begin
      res_gesture <= gest;
      res_arm_ok <= cmd.arm_ok;
    end
  end

  // Detector state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0;
      sy <= '0;
      sz <= '0;
      primed <= 1'b0;
      armed <= 1'b0;
      ref_taken <= 1'b0;
      ref_p <= '0;
      ref_r <= '0;
      steady_class <= G_NONE;
      steady_count <= '0;
      locked_class <= G_NONE;
      waiting_class <= G_NONE;
      waiting_since <= '0;
      gest <= G_NONE;
    end else begin
      if (cmd.capture) begin
        gest <= G_NONE;
      end
      if (cmd.clr_all) begin
        sx <= '0;
        sy <= '0;
        sz <= '0;
        primed <= 1'b0;
        armed <= 1'b0;
        ref_taken <= 1'b0;
        ref_p <= '0;
        ref_r <= '0;
        steady_class <= G_NONE;
        steady_count <= '0;
        locked_class <= G_NONE;
        waiting_class <= G_NONE;
        waiting_since <= '0;
      end
      if (cmd.set_arm) begin
        armed <= 1'b1;
      end
      if (cmd.load_raw || (cmd.load_smooth && !primed)) begin
        sx <= {ax, 8'd0};
        sy <= {ay, 8'd0};
        sz <= {az, 8'd0};
        primed <= 1'b1;
      end else if (cmd.load_smooth) begin
        sx <= iir(sx, ax);
        sy <= iir(sy, ay);
        sz <= iir(sz, az);
      end
      if (cmd.store_ref) begin
        ref_p <= pitch;
        ref_r <= roll;
        ref_taken <= 1'b1;
        steady_class <= G_NONE;
        steady_count <= '0;
        locked_class <= G_NONE;
        waiting_class <= G_NONE;
        waiting_since <= '0;
      end
      if (cmd.detect) begin
        steady_class <= steady_class_next;
        steady_count <= steady_count_next;
        locked_class <= locked_class_next;
        waiting_class <= waiting_class_next;
        waiting_since <= waiting_since_next;
        gest <= gest_next;
      end
    end
  end

endmodule
`default_nettype wire
